### rtl/ethc_pkg.sv
// Shared types, constants and helpers for the temperature/humidity compensation block.
// No dependencies; every other file imports this package.
package ethc_pkg;

	localparam int RAW_T_W  = 20;
	localparam int RAW_H_W  = 16;
	localparam int TEMP_W   = 24;
	localparam int FINE_W   = 32;
	localparam int HUM_W    = 17;
	localparam int CFG_DW   = 24;
	localparam int CFG_IW   = 8;
	localparam int NSTAGE   = 8;

	// arithmetic constants of the compensation scheme
	localparam logic signed [31:0] FINE_OFS   = 32'sd76800;
	localparam logic signed [31:0] HUM_MAX    = 32'sd419430400;
	localparam logic signed [31:0] P_RND      = 32'sd16384;
	localparam logic signed [31:0] Q_OFS      = 32'sd2097152;
	localparam logic signed [31:0] Q_RND      = 32'sd8192;
	localparam logic signed [31:0] H3_OFS     = 32'sd32768;
	localparam logic signed [31:0] T_RND      = 32'sd128;
	localparam logic signed [TEMP_W-1:0] TEMP_POS_SAT = 24'sh7FFFFF;
	localparam logic signed [TEMP_W-1:0] TEMP_NEG_SAT = 24'sh800000;

	typedef enum logic [CFG_IW-1:0] {
		REG_TEMP_CAL_1  = 8'd0,
		REG_TEMP_CAL_2  = 8'd1,
		REG_TEMP_CAL_3  = 8'd2,
		REG_HUM_CAL_1   = 8'd3,
		REG_HUM_CAL_2   = 8'd4,
		REG_HUM_CAL_3   = 8'd5,
		REG_HUM_CAL_4_5 = 8'd6,
		REG_HUM_CAL_6   = 8'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [23:0] h45;
		logic [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic [NSTAGE-1:0] ld;
		logic [NSTAGE-1:0] vld;
	} pctl_t;

	function automatic logic signed [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic signed [31:0] sx12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic logic signed [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic signed [31:0] zx8(input logic [7:0] v);
		return {24'd0, v};
	endfunction

endpackage

### rtl/ethc_in_if.sv
// Request channel carrying one raw temperature/humidity reading pair.
// Depends on ethc_pkg for field widths.
interface ethc_in_if;
	import ethc_pkg::*;
	logic               valid;
	logic               ready;
	logic [RAW_T_W-1:0] raw_temperature;
	logic [RAW_H_W-1:0] raw_humidity;

	modport source(output valid, raw_temperature, raw_humidity, input ready);
	modport sink(input valid, raw_temperature, raw_humidity, output ready);
endinterface

### rtl/ethc_out_if.sv
// Result channel carrying compensated temperature, fine term and humidity.
// Depends on ethc_pkg for field widths.
interface ethc_out_if;
	import ethc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [FINE_W-1:0] fine_temperature;
	logic [HUM_W-1:0]         humidity_q10;

	modport source(output valid, temperature_centi, fine_temperature, humidity_q10,
		input ready);
	modport sink(input valid, temperature_centi, fine_temperature, humidity_q10,
		output ready);
endinterface

### rtl/ethc_cfg.sv
// Calibration register file, write-only, all registers reset to zero.
// Depends on ethc_pkg.
module ethc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ethc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ethc_pkg::CFG_DW-1:0] cfg_wdata,
	output ethc_pkg::cal_t             cal
);
	import ethc_pkg::*;

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_CAL_1: begin
					cal_q.t1 <= cfg_wdata[15:0];
				end
				REG_TEMP_CAL_2: begin
					cal_q.t2 <= cfg_wdata[15:0];
				end
				REG_TEMP_CAL_3: begin
					cal_q.t3 <= cfg_wdata[15:0];
				end
				REG_HUM_CAL_1: begin
					cal_q.h1 <= cfg_wdata[7:0];
				end
				REG_HUM_CAL_2: begin
					cal_q.h2 <= cfg_wdata[15:0];
				end
				REG_HUM_CAL_3: begin
					cal_q.h3 <= cfg_wdata[7:0];
				end
				REG_HUM_CAL_4_5: begin
					cal_q.h45 <= cfg_wdata[23:0];
				end
				REG_HUM_CAL_6: begin
					cal_q.h6 <= cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cal = cal_q;
endmodule

### rtl/ethc_pipe.sv
// Pipeline flow control: per-stage valid bits and load enables with bubble collapse.
// Depends on ethc_pkg.
module ethc_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	output ethc_pkg::pctl_t ctl
);
	import ethc_pkg::*;

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] ld;
	logic              run_q;

	// a stage loads when it is empty or its content moves on;
	// the first stage stays closed until run_q is set after reset
	always_comb begin
		ld[NSTAGE-1] = ~vld_q[NSTAGE-1] | out_ready;
		for (int k = NSTAGE - 2; k >= 1; k--) begin
			ld[k] = ~vld_q[k] | ld[k+1];
		end
		ld[0] = run_q & (~vld_q[0] | ld[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.ld  = ld;
	assign ctl.vld = vld_q;
endmodule

### rtl/ethc_temp.sv
// Stages 1-3: fine temperature, centi-degree temperature and first humidity products.
// Depends on ethc_pkg.
module ethc_temp (
	input  logic                               clk,
	input  ethc_pkg::pctl_t                    ctl,
	input  ethc_pkg::cal_t                     cal,
	input  logic [ethc_pkg::RAW_T_W-1:0]       raw_temperature,
	input  logic [ethc_pkg::RAW_H_W-1:0]       raw_humidity,
	output logic signed [ethc_pkg::TEMP_W-1:0] tc_s3,
	output logic signed [31:0]                 fine_s3,
	output logic signed [31:0]                 hx5_s3,
	output logic signed [31:0]                 m6_s3,
	output logic signed [31:0]                 m3_s3,
	output logic [ethc_pkg::RAW_H_W-1:0]       adc_h_s3
);
	import ethc_pkg::*;

	logic signed [31:0] d1, prod_a, b0, bsq;
	logic signed [31:0] pa_s1, bsq_s1;
	logic [RAW_H_W-1:0] adc_h_s1, adc_h_s2;
	logic signed [31:0] prod_b, fine;
	logic signed [31:0] fine_s2;
	logic signed [31:0] t5, t, x, hx5, x6, x3;
	logic signed [TEMP_W-1:0] tc;

	// stage 1: two independent squares/products of the raw reading
	always_comb begin
		d1     = {15'd0, raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
		prod_a = d1 * sx16(cal.t2);
		b0     = {16'd0, raw_temperature[19:4]} - {16'd0, cal.t1};
		bsq    = b0 * b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			pa_s1    <= prod_a >>> 11;
			bsq_s1   <= bsq >>> 12;
			adc_h_s1 <= raw_humidity;
		end
	end

	// stage 2: fine temperature
	always_comb begin
		prod_b = bsq_s1 * sx16(cal.t3);
		fine   = pa_s1 + (prod_b >>> 14);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			fine_s2  <= fine;
			adc_h_s2 <= adc_h_s1;
		end
	end

	// stage 3: centi-degree output and the fine-term humidity products
	always_comb begin
		t5 = (fine_s2 <<< 2) + fine_s2 + T_RND;
		t  = t5 >>> 8;
		if (t[31:23] == {9{t[23]}}) begin
			tc = t[23:0];
		end else if (t[31]) begin
			tc = TEMP_NEG_SAT;
		end else begin
			tc = TEMP_POS_SAT;
		end
		x   = fine_s2 - FINE_OFS;
		hx5 = sx12(cal.h45[23:12]) * x;
		x6  = x * sx8(cal.h6);
		x3  = x * zx8(cal.h3);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			tc_s3    <= tc;
			fine_s3  <= fine_s2;
			hx5_s3   <= hx5;
			m6_s3    <= x6 >>> 10;
			m3_s3    <= (x3 >>> 11) + H3_OFS;
			adc_h_s3 <= adc_h_s2;
		end
	end
endmodule

### rtl/ethc_hum.sv
// Stages 4-8: humidity compensation, clamp, and the output register.
// Depends on ethc_pkg; fed by ethc_temp.
module ethc_hum (
	input  logic                               clk,
	input  ethc_pkg::pctl_t                    ctl,
	input  ethc_pkg::cal_t                     cal,
	input  logic signed [ethc_pkg::TEMP_W-1:0] tc_s3,
	input  logic signed [31:0]                 fine_s3,
	input  logic signed [31:0]                 hx5_s3,
	input  logic signed [31:0]                 m6_s3,
	input  logic signed [31:0]                 m3_s3,
	input  logic [ethc_pkg::RAW_H_W-1:0]       adc_h_s3,
	output logic signed [ethc_pkg::TEMP_W-1:0] tc_s8,
	output logic signed [31:0]                 fine_s8,
	output logic [ethc_pkg::HUM_W-1:0]         hum_s8
);
	import ethc_pkg::*;

	logic signed [31:0] p_sum, q1;
	logic signed [31:0] p_s4, q1_s4, p_s5, q_s5, x_s6, x_s7, sq_s7;
	logic signed [31:0] q2, y, ysq, z, x2, hc;
	logic signed [TEMP_W-1:0] tc_s4, tc_s5, tc_s6, tc_s7;
	logic signed [31:0] fine_s4, fine_s5, fine_s6, fine_s7;

	// stage 4: offset term and the h6/h3 product
	always_comb begin
		p_sum = {2'd0, adc_h_s3, 14'd0} - (sx12(cal.h45[11:0]) <<< 20) - hx5_s3 + P_RND;
		q1    = m6_s3 * m3_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			p_s4    <= p_sum >>> 15;
			q1_s4   <= q1;
			tc_s4   <= tc_s3;
			fine_s4 <= fine_s3;
		end
	end

	// stage 5: scale by h2
	always_comb begin
		q2 = ((q1_s4 >>> 10) + Q_OFS) * sx16(cal.h2) + Q_RND;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			p_s5    <= p_s4;
			q_s5    <= q2 >>> 14;
			tc_s5   <= tc_s4;
			fine_s5 <= fine_s4;
		end
	end

	// stage 6: raw humidity product
	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			x_s6    <= p_s5 * q_s5;
			tc_s6   <= tc_s5;
			fine_s6 <= fine_s5;
		end
	end

	// stage 7: square of the upper part
	always_comb begin
		y   = x_s6 >>> 15;
		ysq = y * y;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[6]) begin
			x_s7    <= x_s6;
			sq_s7   <= ysq >>> 7;
			tc_s7   <= tc_s6;
			fine_s7 <= fine_s6;
		end
	end

	// stage 8: h1 correction, clamp to 0..100 percent
	always_comb begin
		z  = (sq_s7 * zx8(cal.h1)) >>> 4;
		x2 = x_s7 - z;
		if (x2[31]) begin
			hc = '0;
		end else if (x2 > HUM_MAX) begin
			hc = HUM_MAX;
		end else begin
			hc = x2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[7]) begin
			hum_s8  <= hc[28:12];
			tc_s8   <= tc_s7;
			fine_s8 <= fine_s7;
		end
	end
endmodule

### rtl/env_sensor_temp_humidity_compensate.sv
// Top level of the temperature/humidity compensation block.
// Depends on ethc_pkg, ethc_in_if, ethc_out_if, ethc_cfg, ethc_pipe, ethc_temp, ethc_hum.
//
// Converts one raw 20-bit temperature and one raw 16-bit humidity reading into
// temperature in 0.01 degC, the 32-bit fine temperature term, and relative humidity
// in Q7.10 percent clamped to 0..100 percent, using the standard 32-bit integer
// compensation (all intermediates wrap to 32 bits, shifts are arithmetic).
// Throughput: one request per cycle while the output is not stalled. The result
// is held in the output register, the last of eight register stages, each at
// most one 32x32 multiply deep.
// Flow control is per stage: a stage loads whenever it is empty or its content
// moves on, so bubbles collapse and a stalled result in the output register does
// not stop earlier stages from filling. in_ch.ready depends combinationally on
// out_ch.ready, and stays low during reset and until run_q is set after it.
// Calibration registers (index 0..7, reset 0) are written through
// cfg_we/cfg_index/cfg_wdata and must only change while the pipeline is empty;
// writes to other indexes are ignored. Coefficients four and five are taken as
// signed 12-bit values from bits 11:0 and 23:12 of register 6.
module env_sensor_temp_humidity_compensate (
	input  logic                        clk,
	input  logic                        arst_n,
	ethc_in_if.sink                     in_ch,
	ethc_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [ethc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ethc_pkg::CFG_DW-1:0] cfg_wdata
);
	import ethc_pkg::*;

	cal_t  cal;
	pctl_t ctl;

	logic signed [TEMP_W-1:0] tc_s3, tc_s8;
	logic signed [31:0]       fine_s3, hx5_s3, m6_s3, m3_s3, fine_s8;
	logic [RAW_H_W-1:0]       adc_h_s3;
	logic [HUM_W-1:0]         hum_s8;

	ethc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cal       (cal)
	);

	// valid bits and stage load enables
	ethc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl)
	);

	// stages 1-3
	ethc_temp u_temp (
		.clk             (clk),
		.ctl             (ctl),
		.cal             (cal),
		.raw_temperature (in_ch.raw_temperature),
		.raw_humidity    (in_ch.raw_humidity),
		.tc_s3           (tc_s3),
		.fine_s3         (fine_s3),
		.hx5_s3          (hx5_s3),
		.m6_s3           (m6_s3),
		.m3_s3           (m3_s3),
		.adc_h_s3        (adc_h_s3)
	);

	// stages 4-8, last one is the output register
	ethc_hum u_hum (
		.clk      (clk),
		.ctl      (ctl),
		.cal      (cal),
		.tc_s3    (tc_s3),
		.fine_s3  (fine_s3),
		.hx5_s3   (hx5_s3),
		.m6_s3    (m6_s3),
		.m3_s3    (m3_s3),
		.adc_h_s3 (adc_h_s3),
		.tc_s8    (tc_s8),
		.fine_s8  (fine_s8),
		.hum_s8   (hum_s8)
	);

	assign in_ch.ready              = ctl.ld[0];
	assign out_ch.valid             = ctl.vld[NSTAGE-1];
	assign out_ch.temperature_centi = tc_s8;
	assign out_ch.fine_temperature  = fine_s8;
	assign out_ch.humidity_q10      = hum_s8;
endmodule

### dv/ethc_tb_pkg.sv
`timescale 1ns / 100ps
// Testbench package: calibration coefficient set and the compensation scoreboard.
// Depends on ethc_pkg for widths, register indexes and scheme constants.
package ethc_tb_pkg;
	import ethc_pkg::*;

	localparam logic signed [31:0] TEMP_CEIL  = 32'sd8388607;
	localparam logic signed [31:0] TEMP_FLOOR = -32'sd8388608;
	localparam int REPORT_CAP = 40;

	// one full set of calibration coefficients, raw register bit patterns
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} coef_set_t;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic signed [FINE_W-1:0] fine;
		logic [HUM_W-1:0]         hum;
	} comp_result_t;

	class comp_scoreboard;
		logic [15:0] cal_t1, cal_t2, cal_t3, cal_h2;
		logic [7:0]  cal_h1, cal_h3, cal_h6;
		logic [23:0] cal_h45;
		comp_result_t pending_comp[$];
		int mismatches;

		function new();
			{cal_t1, cal_t2, cal_t3, cal_h2} = '0;
			{cal_h1, cal_h3, cal_h6, cal_h45} = '0;
			mismatches = 0;
		endfunction

		// mirror of a register write; narrow registers keep only their low bits
		function void write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
			case (idx)
				REG_TEMP_CAL_1:  cal_t1  = data[15:0];
				REG_TEMP_CAL_2:  cal_t2  = data[15:0];
				REG_TEMP_CAL_3:  cal_t3  = data[15:0];
				REG_HUM_CAL_1:   cal_h1  = data[7:0];
				REG_HUM_CAL_2:   cal_h2  = data[15:0];
				REG_HUM_CAL_3:   cal_h3  = data[7:0];
				REG_HUM_CAL_4_5: cal_h45 = data;
				REG_HUM_CAL_6:   cal_h6  = data[7:0];
				default: ;
			endcase
		endfunction

		// 32-bit wrapping integer compensation, arithmetic shifts throughout
		function comp_result_t compensate(input logic [RAW_T_W-1:0] adc_t,
				input logic [RAW_H_W-1:0] adc_h);
			logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
			logic signed [31:0] at, ah, a, b, fine, t, x, p, q, v, sq;
			comp_result_t r;
			t1 = {16'd0, cal_t1};
			t2 = {{16{cal_t2[15]}}, cal_t2};
			t3 = {{16{cal_t3[15]}}, cal_t3};
			h1 = {24'd0, cal_h1};
			h2 = {{16{cal_h2[15]}}, cal_h2};
			h3 = {24'd0, cal_h3};
			h4 = {{20{cal_h45[11]}}, cal_h45[11:0]};
			h5 = {{20{cal_h45[23]}}, cal_h45[23:12]};
			h6 = {{24{cal_h6[7]}}, cal_h6};
			at = {12'd0, adc_t};
			ah = {16'd0, adc_h};

			a = (at >>> 3) - (t1 <<< 1);
			a = a * t2;
			a = a >>> 11;
			b = (at >>> 4) - t1;
			b = b * b;
			b = b >>> 12;
			b = b * t3;
			b = b >>> 14;
			fine = a + b;
			t = fine * 5 + T_RND;
			t = t >>> 8;
			if (t > TEMP_CEIL)
				t = TEMP_CEIL;
			if (t < TEMP_FLOOR)
				t = TEMP_FLOOR;

			x = fine - FINE_OFS;
			p = ah <<< 14;
			p = p - (h4 <<< 20);
			p = p - h5 * x;
			p = p + P_RND;
			p = p >>> 15;
			v = x * h6;
			v = v >>> 10;
			q = x * h3;
			q = q >>> 11;
			q = q + H3_OFS;
			q = v * q;
			q = q >>> 10;
			q = q + Q_OFS;
			q = q * h2;
			q = q + Q_RND;
			q = q >>> 14;
			x = p * q;
			sq = x >>> 15;
			sq = sq * sq;
			sq = sq >>> 7;
			sq = sq * h1;
			sq = sq >>> 4;
			x = x - sq;
			if (x < 0)
				x = 0;
			if (x > HUM_MAX)
				x = HUM_MAX;

			r.temp = t[TEMP_W-1:0];
			r.fine = fine;
			r.hum  = x[28:12];
			return r;
		endfunction

		function void note_reading(input logic [RAW_T_W-1:0] adc_t,
				input logic [RAW_H_W-1:0] adc_h);
			pending_comp.push_back(compensate(adc_t, adc_h));
		endfunction

		function int outstanding();
			return pending_comp.size();
		endfunction

		task report(input string msg);
			if (mismatches < REPORT_CAP)
				$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(input logic signed [TEMP_W-1:0] temp,
				input logic signed [FINE_W-1:0] fine, input logic [HUM_W-1:0] hum);
			comp_result_t want;
			if (pending_comp.size() == 0) begin
				report($sformatf("unexpected result temp=%0d fine=%0d hum=%0d",
					temp, fine, hum));
				return;
			end
			want = pending_comp.pop_front();
			if (temp !== want.temp)
				report($sformatf("temperature_centi got %0d want %0d", temp, want.temp));
			if (fine !== want.fine)
				report($sformatf("fine_temperature got %0d want %0d", fine, want.fine));
			if (hum !== want.hum)
				report($sformatf("humidity_q10 got %0d want %0d", hum, want.hum));
		endtask
	endclass

endpackage

### dv/env_sensor_temp_humidity_compensate_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for env_sensor_temp_humidity_compensate: directed and random
// readings under fixed and random calibration, checked against an in-bench predictor.
// Depends on ethc_pkg, ethc_in_if, ethc_out_if and ethc_tb_pkg.
module env_sensor_temp_humidity_compensate_tb;
	import ethc_pkg::*;
	import ethc_tb_pkg::*;

	localparam int IDLE_LIMIT    = 5000;	// cycles with no handshake on either side
	localparam int LONG_HOLD     = 400;	// receiver hold-off, well past pipeline depth
	localparam int N_PHASES      = 8;
	localparam int PHASE_ITEMS   = 135;
	localparam int FLOOD_ITEMS   = 150;
	localparam logic [CFG_IW-1:0] REG_UNMAPPED = 8'hA5;

	// nominal calibration of a typical part
	localparam coef_set_t COEF_TYPICAL = '{t1: 16'd27504, t2: 16'd26435, t3: -16'sd1000,
		h1: 8'd75, h2: 16'd362, h3: 8'd0, h4: 12'd313, h5: 12'd50, h6: 8'd30};
	// every coefficient at its top value; h4/h5 all ones read as -1
	localparam coef_set_t COEF_ALL_MAX = '{t1: 16'hFFFF, t2: 16'h7FFF, t3: 16'h7FFF,
		h1: 8'hFF, h2: 16'h7FFF, h3: 8'hFF, h4: 12'hFFF, h5: 12'hFFF, h6: 8'h7F};
	// signed coefficients at their most negative
	localparam coef_set_t COEF_ALL_MIN = '{t1: 16'h0000, t2: 16'h8000, t3: 16'h8000,
		h1: 8'h00, h2: 16'h8000, h3: 8'h00, h4: 12'h800, h5: 12'h800, h6: 8'h80};
	// signed coefficients at their most positive, unsigned ones mid scale
	localparam coef_set_t COEF_POS_MAX = '{t1: 16'h8000, t2: 16'h7FFF, t3: 16'h7FFF,
		h1: 8'h80, h2: 16'h7FFF, h3: 8'h80, h4: 12'h7FF, h5: 12'h7FF, h6: 8'h7F};

	typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;

	ethc_in_if  in_ch();
	ethc_out_if out_ch();

	comp_scoreboard sb;
	bit hold_req;	// stimulus asks the receiver for one long hold-off
	int idle_cycles;

	env_sensor_temp_humidity_compensate uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Handshake monitor. Runs in the active region of the rising edge, before the
	// block's flops update, so it sees the values that the edge accepts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_reading(in_ch.raw_temperature, in_ch.raw_humidity);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.temperature_centi, out_ch.fine_temperature,
					out_ch.humidity_q10);
		end
	end

	// Watchdog: any request or result moving resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("env_sensor_temp_humidity_compensate_tb: FAIL");
			$finish;
		end
	end

	// Receiver: ready follows random segments of one mode each; a hold request
	// from the stimulus forces a long stall counted here.
	initial begin
		int seg_left;
		rx_mode_t rx_mode;
		seg_left = 0;
		rx_mode = RX_ALWAYS;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(1, 64);
					rx_mode = rx_mode_t'($urandom_range(0, 3));
				end
				seg_left--;
				case (rx_mode)
					RX_ALWAYS: out_ch.ready <= 1'b1;
					RX_HALF:   out_ch.ready <= $urandom_range(0, 1);
					RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 4) != 0);
					RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Present one request and hold it until accepted. valid stays high on return,
	// so back-to-back calls give a gapless burst.
	task automatic offer_reading(input logic [RAW_T_W-1:0] rt, input logic [RAW_H_W-1:0] rh);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.raw_temperature <= rt;
		in_ch.raw_humidity <= rh;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic drain();
		pause_sender(1);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_coefs(input coef_set_t c);
		write_reg(REG_TEMP_CAL_1, {8'd0, c.t1});
		write_reg(REG_TEMP_CAL_2, {8'd0, c.t2});
		write_reg(REG_TEMP_CAL_3, {8'd0, c.t3});
		write_reg(REG_HUM_CAL_1, {16'd0, c.h1});
		write_reg(REG_HUM_CAL_2, {8'd0, c.h2});
		write_reg(REG_HUM_CAL_3, {16'd0, c.h3});
		write_reg(REG_HUM_CAL_4_5, {c.h5, c.h4});
		write_reg(REG_HUM_CAL_6, {16'd0, c.h6});
	endtask

	// Plausible parts when plausible is set, arbitrary bit patterns otherwise.
	function automatic coef_set_t random_coefs(input bit plausible);
		coef_set_t c;
		if (plausible) begin
			c.t1 = 16'(26000 + $urandom_range(0, 3000));
			c.t2 = 16'(25000 + $urandom_range(0, 3000));
			c.t3 = 16'(-int'($urandom_range(0, 2000)));
			c.h1 = 8'($urandom_range(0, 255));
			c.h2 = 16'(300 + $urandom_range(0, 150));
			c.h3 = 8'($urandom_range(0, 255));
			c.h4 = 12'(250 + $urandom_range(0, 150));
			c.h5 = 12'(int'($urandom_range(0, 120)) - 20);
			c.h6 = 8'($urandom_range(0, 60));
		end else begin
			c = coef_set_t'({$urandom, $urandom, $urandom, $urandom});
		end
		return c;
	endfunction

	task automatic random_reading(output logic [RAW_T_W-1:0] rt, output logic [RAW_H_W-1:0] rh);
		case ($urandom_range(0, 3))
			0, 1: begin
				// room-ish conditions
				rt = 20'(380000 + $urandom_range(0, 250000));
				rh = 16'($urandom_range(15000, 60000));
			end
			2: begin
				rt = 20'($urandom);
				rh = 16'($urandom);
			end
			default: begin
				// rails mixed with noise
				rt = ($urandom_range(0, 2) == 0) ? '0 :
					($urandom_range(0, 1) ? '1 : 20'($urandom));
				rh = ($urandom_range(0, 2) == 0) ? '0 :
					($urandom_range(0, 1) ? '1 : 16'($urandom));
			end
		endcase
	endtask

	// Random requests in bursts; the occasional long burst has no idling at all.
	task automatic run_traffic(input int count);
		int remaining;
		int burst;
		int gap;
		logic [RAW_T_W-1:0] rt;
		logic [RAW_H_W-1:0] rh;
		remaining = count;
		while (remaining > 0) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
			gap = $urandom_range(0, 12);
			for (int i = 0; i < burst && remaining > 0; i++) begin
				random_reading(rt, rh);
				offer_reading(rt, rh);
				remaining--;
			end
			pause_sender(gap);
		end
	endtask

	// Directed corners: rails of both fields, a mid-scale pair and a room reading.
	task automatic corner_readings();
		offer_reading('0, '0);
		offer_reading('1, '1);
		offer_reading(20'h80000, 16'h8000);
		offer_reading(20'd519888, 16'd30000);
	endtask

	initial begin
		logic [RAW_T_W-1:0] rt;
		logic [RAW_H_W-1:0] rh;
		sb = new();
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.raw_temperature = '0;
		in_ch.raw_humidity = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// coefficients still at reset: all zero
		offer_reading('0, '0);
		offer_reading('1, '1);
		drain();

		// typical part: room reading, humidity clamped at 0 and at 100 percent
		program_coefs(COEF_TYPICAL);
		offer_reading(20'd519888, 16'd30000);
		offer_reading(20'd519888, 16'd0);
		offer_reading(20'd519888, 16'hFFFF);
		offer_reading(20'd415148, 16'd40000);
		offer_reading('0, '0);
		offer_reading('1, '1);
		drain();

		// bits above a register's width are dropped; an unmapped index is ignored,
		// so results must match the typical set again
		write_reg(REG_UNMAPPED, '1);
		write_reg(REG_HUM_CAL_1, 24'hABCD4B);
		write_reg(REG_TEMP_CAL_2, 24'h5A6743);
		offer_reading(20'd519888, 16'd30000);
		offer_reading(20'd600000, 16'd20000);
		drain();

		// coefficient extremes, wrap-around in every intermediate product
		program_coefs(COEF_ALL_MAX);
		corner_readings();
		drain();
		program_coefs(COEF_ALL_MIN);
		corner_readings();
		drain();
		program_coefs(COEF_POS_MAX);
		corner_readings();
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			program_coefs(random_coefs(ph % 2 == 0));
			if (ph == 3) begin
				// flood: receiver stalls long while the sender keeps offering,
				// so the pipeline fills and backs up into the request channel
				hold_req = 1'b1;
				for (int i = 0; i < FLOOD_ITEMS; i++) begin
					random_reading(rt, rh);
					offer_reading(rt, rh);
				end
				run_traffic(PHASE_ITEMS - FLOOD_ITEMS / 2);
			end else if (ph == 5) begin
				// sender waits mid-phase for every result before carrying on
				run_traffic(PHASE_ITEMS / 2);
				drain();
				run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				run_traffic(PHASE_ITEMS);
			end
			drain();
		end

		// settle to catch stray results
		repeat (2 * NSTAGE) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("env_sensor_temp_humidity_compensate_tb: PASS");
		else
			$display("env_sensor_temp_humidity_compensate_tb: FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/ethc_pkg.sv
rtl/ethc_in_if.sv
rtl/ethc_out_if.sv
rtl/ethc_cfg.sv
rtl/ethc_pipe.sv
rtl/ethc_temp.sv
rtl/ethc_hum.sv
rtl/env_sensor_temp_humidity_compensate.sv
dv/ethc_tb_pkg.sv
dv/env_sensor_temp_humidity_compensate_tb.sv
